### rtl/macd_pkg.sv
`timescale 1ns / 1ps
package macd_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int PRICE_BITS = 32;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = 7;
  localparam int SEEN_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = PRICE_BITS + ADDR_W + 1;
  localparam int DIV_W      = SUM_W - 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int DVSR_W     = $clog2(MAX_WINDOW + 2);
  localparam int RATE_W     = 17;
  localparam int ENTRY_W    = PRICE_BITS + 1;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 2'd2;

  localparam logic [LEN_W-1:0] FAST_RESET   = 7'd12;
  localparam logic [LEN_W-1:0] SLOW_RESET   = 7'd26;
  localparam logic [LEN_W-1:0] SIGNAL_RESET = 7'd9;

  // 2.0 in unsigned Q.16, the numerator of the smoothing factor
  localparam logic [DIV_W-1:0] RATE_NUM = DIV_W'(2 ** (RATE_W));

  typedef struct packed {
    logic                         miss;
    logic signed [PRICE_BITS-1:0] price;
  } item_t;

  typedef struct packed {
    logic signed [PRICE_BITS-1:0] macd_value;
    logic signed [PRICE_BITS-1:0] signal_value;
    logic signed [PRICE_BITS-1:0] histogram_value;
    logic                         macd_valid;
    logic                         signal_valid;
    logic                         histogram_valid;
    logic                         config_error;
  } result_t;

  // Clamp a difference back to the price width
  function automatic logic signed [PRICE_BITS-1:0] sat_diff(
    input logic signed [PRICE_BITS:0] v
  );
    logic signed [PRICE_BITS-1:0] r;
    if (v[PRICE_BITS] != v[PRICE_BITS-1]) begin
      r = v[PRICE_BITS] ? {1'b1, {(PRICE_BITS-1){1'b0}}} : {1'b0, {(PRICE_BITS-1){1'b1}}};
    end else begin
      r = v[PRICE_BITS-1:0];
    end
    return r;
  endfunction

  // Length register to working window length
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] r);
    logic [LEN_W-1:0] e;
    if (r == '0) begin
      e = LEN_W'(1);
    end else if (r > LEN_W'(MAX_WINDOW)) begin
      e = LEN_W'(MAX_WINDOW);
    end else begin
      e = r;
    end
    return e;
  endfunction

endpackage

### rtl/macd_ram.sv
`timescale 1ns / 1ps
module macd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/macd_front.sv
`timescale 1ns / 1ps
module macd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  macd_pkg::item_t                  in_item,
  output logic                             q_valid,
  input  logic                             q_pop,
  output macd_pkg::item_t                  q_item
);
  import macd_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Store incoming transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/macd_div.sv
`timescale 1ns / 1ps
module macd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [macd_pkg::DIV_W-1:0]  dividend,
  input  logic [macd_pkg::DVSR_W-1:0] divisor,
  output logic                        done,
  output logic [macd_pkg::DIV_W-1:0]  quotient
);
  import macd_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  step;
  logic [DVSR_W-1:0]     rem;
  logic [DVSR_W-1:0]     dvsr;
  logic [DVSR_W:0]       trial;
  logic                  fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvsr     <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? DVSR_W'(trial - {1'b0, dvsr}) : trial[DVSR_W-1:0];
        quotient <= {quotient[DIV_W-2:0], fits};
        step     <= step + DIV_CNT_W'(1);
        if (step == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/macd_core.sv
`timescale 1ns / 1ps
module macd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [macd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [macd_pkg::LEN_W-1:0]    cfg_val,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  macd_pkg::item_t               q_item,
  output logic                          res_valid,
  input  logic                          res_take,
  output macd_pkg::result_t             res
);
  import macd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_UPD, S_DEC, S_SEED, S_RATE, S_MUL, S_ADD, S_MACD, S_FIN
  } state_t;

  state_t                       state;
  logic [LEN_W-1:0]             fast_len, slow_len, sig_len;
  logic [ADDR_W-1:0]            pos;
  logic [SEEN_W-1:0]            seen;
  logic signed [SUM_W-1:0]      sum [3];
  logic [LEN_W-1:0]             miss_cnt [3];
  logic signed [PRICE_BITS-1:0] avg [3];
  logic [2:0]                   seeded;
  logic [2:0]                   ok;
  logic [ENTRY_W-1:0]           outgoing [3];
  logic [1:0]                   ch;
  item_t                        cur;
  logic                         macd_ok;
  logic signed [PRICE_BITS-1:0] macd;
  logic [RATE_W-1:0]            rate;
  logic [PRICE_BITS-1:0]        amag;
  logic                         dneg;
  logic [PRICE_BITS+RATE_W-1:0] prod;
  logic                         clear;

  logic [LEN_W-1:0]             fl, sl, gl, w;
  logic signed [PRICE_BITS-1:0] x;
  logic                         mx;
  logic [ENTRY_W-1:0]           og;
  logic signed [SUM_W-1:0]      sum_a, sum_b;
  logic [LEN_W-1:0]             cnt_a, cnt_b;
  logic [SUM_W-1:0]             sum_abs;
  logic                         div_start;
  logic [DIV_W-1:0]             div_num;
  logic [DVSR_W-1:0]            div_den;
  logic                         div_done;
  logic [DIV_W-1:0]             div_q;
  logic signed [PRICE_BITS:0]   diff;
  logic [PRICE_BITS:0]          step_p;
  logic [ADDR_W-1:0]            price_raddr, macd_raddr;
  logic [ENTRY_W-1:0]           price_rdata, macd_rdata;
  logic                         wr_hist;
  logic signed [PRICE_BITS-1:0] sig_v;
  logic                         hist_ok;
  logic                         err;

  assign fl = eff_len(fast_len);
  assign sl = eff_len(slow_len);
  assign gl = eff_len(sig_len);

  // Select the operands of the average being worked on
  always_comb begin
    case (ch)
      2'd0:    w = fl;
      2'd1:    w = sl;
      default: w = gl;
    endcase
    x  = (ch == 2'd2) ? macd : cur.price;
    mx = (ch == 2'd2) ? !macd_ok : cur.miss;
    og = outgoing[ch];
  end

  // Window sum and missing count after this input enters and, once the window is full, the oldest leaves
  always_comb begin
    sum_a = sum[ch];
    cnt_a = miss_cnt[ch];
    if (mx) begin
      cnt_a = miss_cnt[ch] + LEN_W'(1);
    end else begin
      sum_a = sum[ch] + SUM_W'(x);
    end
    sum_b = sum_a;
    cnt_b = cnt_a;
    if (seen >= SEEN_W'(w)) begin
      if (og[PRICE_BITS]) begin
        if (cnt_a != '0) begin
          cnt_b = cnt_a - LEN_W'(1);
        end
      end else begin
        sum_b = sum_a - SUM_W'($signed(og[PRICE_BITS-1:0]));
      end
    end
  end

  assign sum_abs = sum[ch][SUM_W-1] ? SUM_W'(-sum[ch]) : SUM_W'(sum[ch]);
  assign diff    = {x[PRICE_BITS-1], x} - {avg[ch][PRICE_BITS-1], avg[ch]};
  assign step_p  = prod[PRICE_BITS+RATE_W-1:RATE_W-1];

  // Divider operands: seed mean or smoothing factor
  always_comb begin
    div_start = 1'b0;
    div_num   = RATE_NUM;
    div_den   = DVSR_W'(w) + DVSR_W'(1);
    if (state == S_DEC) begin
      div_start = 1'b1;
      if (!seeded[ch]) begin
        div_num   = sum_abs[DIV_W-1:0];
        div_den   = DVSR_W'(w);
        div_start = ({1'b0, seen} + (SEEN_W+1)'(1) >= (SEEN_W+1)'(w)) && (miss_cnt[ch] == '0);
      end
    end
  end

  macd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // History reads: fast outgoing issued in idle, slow outgoing issued in S_RD1
  assign price_raddr = (state == S_RD1) ? pos - sl[ADDR_W-1:0] : pos - fl[ADDR_W-1:0];
  assign macd_raddr  = pos - gl[ADDR_W-1:0];
  assign wr_hist     = (state == S_FIN) && res_take;

  macd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINDOW)) u_price_hist (
    .clk   (clk),
    .we    (wr_hist),
    .waddr (pos),
    .wdata (cur.miss ? {1'b1, {PRICE_BITS{1'b0}}} : {1'b0, cur.price}),
    .raddr (price_raddr),
    .rdata (price_rdata)
  );

  macd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINDOW)) u_macd_hist (
    .clk   (clk),
    .we    (wr_hist),
    .waddr (pos),
    .wdata (macd_ok ? {1'b0, macd} : {1'b1, {PRICE_BITS{1'b0}}}),
    .raddr (macd_raddr),
    .rdata (macd_rdata)
  );

  // Result fields
  assign err       = (fast_len >= slow_len);
  assign sig_v     = ok[2] ? avg[2] : '0;
  assign hist_ok   = macd_ok && ok[2];
  assign res_valid = (state == S_FIN);
  assign q_pop     = (state == S_IDLE) && q_valid && !cfg_write;
  assign clear     = cfg_write && (cfg_idx == CFG_FAST || cfg_idx == CFG_SLOW ||
                                   cfg_idx == CFG_SIGNAL);

  always_comb begin
    res.macd_value      = (macd_ok && !err) ? macd : '0;
    res.macd_valid      = macd_ok && !err;
    res.signal_value    = (ok[2] && !err) ? sig_v : '0;
    res.signal_valid    = ok[2] && !err;
    res.histogram_value = (hist_ok && !err) ?
                          sat_diff({macd[PRICE_BITS-1], macd} - {sig_v[PRICE_BITS-1], sig_v}) : '0;
    res.histogram_valid = hist_ok && !err;
    res.config_error    = err;
  end

  // Sequencer: fast, slow, then signal average, one at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fast_len <= FAST_RESET;
      slow_len <= SLOW_RESET;
      sig_len  <= SIGNAL_RESET;
      pos      <= '0;
      seen     <= '0;
      seeded   <= '0;
      ok       <= '0;
      ch       <= '0;
      macd_ok  <= 1'b0;
      macd     <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i]      <= '0;
        miss_cnt[i] <= '0;
        avg[i]      <= '0;
      end
    end else if (clear) begin
      case (cfg_idx)
        CFG_FAST:   fast_len <= cfg_val;
        CFG_SLOW:   slow_len <= cfg_val;
        default:    sig_len  <= cfg_val;
      endcase
      state  <= S_IDLE;
      pos    <= '0;
      seen   <= '0;
      seeded <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i]      <= '0;
        miss_cnt[i] <= '0;
        avg[i]      <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur     <= q_item;
            ch      <= 2'd0;
            macd_ok <= 1'b0;
            macd    <= '0;
            state   <= S_RD1;
          end
        end
        S_RD1: begin
          outgoing[0] <= price_rdata;
          outgoing[2] <= macd_rdata;
          state       <= S_RD2;
        end
        S_RD2: begin
          outgoing[1] <= price_rdata;
          state       <= S_UPD;
        end
        S_UPD: begin
          sum[ch]      <= sum_b;
          miss_cnt[ch] <= cnt_b;
          if (mx) begin
            seeded[ch] <= 1'b0;
          end
          state <= S_DEC;
        end
        S_DEC: begin
          if (!seeded[ch]) begin
            if (div_start) begin
              state <= S_SEED;
            end else begin
              ok[ch] <= 1'b0;
              state  <= (ch == 2'd2) ? S_FIN : ((ch == 2'd1) ? S_MACD : S_UPD);
              ch     <= (ch == 2'd0) ? 2'd1 : ch;
            end
          end else begin
            state <= S_RATE;
          end
        end
        S_SEED: begin
          if (div_done) begin
            avg[ch]    <= sum[ch][SUM_W-1] ? PRICE_BITS'(-div_q) : PRICE_BITS'(div_q);
            seeded[ch] <= 1'b1;
            ok[ch]     <= 1'b1;
            state      <= (ch == 2'd2) ? S_FIN : ((ch == 2'd1) ? S_MACD : S_UPD);
            ch         <= (ch == 2'd0) ? 2'd1 : ch;
          end
        end
        S_RATE: begin
          if (div_done) begin
            rate  <= div_q[RATE_W-1:0];
            dneg  <= diff[PRICE_BITS];
            amag  <= diff[PRICE_BITS] ? PRICE_BITS'(-diff) : PRICE_BITS'(diff);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= amag * rate;
          state <= S_ADD;
        end
        S_ADD: begin
          avg[ch] <= dneg ? PRICE_BITS'(avg[ch] - step_p[PRICE_BITS-1:0])
                          : PRICE_BITS'(avg[ch] + step_p[PRICE_BITS-1:0]);
          ok[ch]  <= 1'b1;
          state   <= (ch == 2'd2) ? S_FIN : ((ch == 2'd1) ? S_MACD : S_UPD);
          ch      <= (ch == 2'd0) ? 2'd1 : ch;
        end
        S_MACD: begin
          macd_ok <= ok[0] && ok[1];
          macd    <= (ok[0] && ok[1]) ?
                     sat_diff({avg[0][PRICE_BITS-1], avg[0]} - {avg[1][PRICE_BITS-1], avg[1]})
                     : '0;
          ch      <= 2'd2;
          state   <= S_UPD;
        end
        S_FIN: begin
          if (res_take) begin
            pos   <= pos + ADDR_W'(1);
            if (seen < SEEN_W'(MAX_WINDOW)) begin
              seen <= seen + SEEN_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/macd_indicator.sv
`timescale 1ns / 1ps
// MACD indicator: one close price in (signed Q16.16, with a missing flag), one
// result out carrying MACD, signal and histogram with their valid flags. An
// item takes least time with no average seeded and most with all three
// averages updating, set by the shared radix-2 divider that works out each seed
// mean or smoothing factor; the three averages run one after another through it
// and one multiplier. A two-entry queue in front and an output register behind
// let either side stall alone. Writing a length register restarts the stream;
// writes must go in only while idle, which the block itself does not enforce.
module macd_indicator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [macd_pkg::PRICE_BITS-1:0]       s_tdata,   // price
  input  logic                                  s_tuser,   // price_missing
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // macd_value, signal_value, histogram_value
  output logic [3*macd_pkg::PRICE_BITS-1:0]     m_tdata,
  // macd_valid, signal_valid, histogram_valid, config_error
  output logic [3:0]                            m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [macd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [macd_pkg::LEN_W-1:0]            cfg_data
);
  import macd_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  logic    res_valid;
  logic    res_take;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{miss: s_tuser, price: s_tdata};
  assign res_take  = res_valid && (!m_tvalid || m_tready);

  macd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  macd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {res.histogram_value, res.signal_value, res.macd_value};
      m_tuser <= {res.config_error, res.histogram_valid, res.signal_valid, res.macd_valid};
    end
  end

endmodule
